@@ hw/rtl/mfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants, codes and types of the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    // Default sizes; the top level hands its own values down.
    localparam int MFS_NUM_TASKS  = 16;
    localparam int MFS_NUM_LEVELS = 5;

    // Fixed field widths of the command port.
    localparam int LVL_IN_W = 3;
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;

    // Command codes.
    localparam logic [OP_W-1:0] OP_ADMIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_SLEEP    = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADM_RD,
        S_ADM_WR,
        S_SLP_RD,
        S_SLP_WR,
        S_WK_LIST,
        S_WK_TASK,
        S_WK_UPD,
        S_REQ_RD,
        S_REQ_WR,
        S_PICK,
        S_PICK_WR,
        S_OUT_RD,
        S_OUT
    } mfs_state_t;

    // Queue pointer commands from the sequencer.
    typedef struct packed {
        logic push;
        logic pop;
    } lvl_ctl_t;

endpackage

@@ hw/rtl/mfs_ram.sv @@
// ----------------------------------------------------------------------------
// mfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/mfs_levels.sv @@
// ----------------------------------------------------------------------------
// mfs_levels
// Head and count pointers of the ready levels; finds the highest busy level.
// ----------------------------------------------------------------------------
module mfs_levels
    import mfs_pkg::*;
#(
    parameter int NUM_TASKS  = MFS_NUM_TASKS,
    parameter int NUM_LEVELS = MFS_NUM_LEVELS,
    localparam int TW = $clog2(NUM_TASKS),
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lvl_ctl_t      ctl,
    input  logic [LW-1:0] push_lvl,
    output logic          push_ok,
    output logic [TW-1:0] push_slot,
    output logic          any_ready,
    output logic [LW-1:0] pop_lvl,
    output logic [TW-1:0] pop_slot
);

    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int SW = $clog2(2 * NUM_TASKS);

    logic [TW-1:0] head_reg  [NUM_LEVELS];
    logic [TW-1:0] head_next [NUM_LEVELS];
    logic [CW-1:0] cnt_reg   [NUM_LEVELS];
    logic [CW-1:0] cnt_next  [NUM_LEVELS];
    logic [SW-1:0] sum;

    // Tail slot of the pushed level, wrapped once.
    always_comb
    begin
        push_ok   = 1'b0;
        sum       = '0;
        push_slot = '0;
        if (push_lvl < LW'(NUM_LEVELS - 1) || push_lvl == LW'(NUM_LEVELS - 1))
        begin
            push_ok = cnt_reg[push_lvl] < CW'(NUM_TASKS);
            sum     = SW'(head_reg[push_lvl]) + SW'(cnt_reg[push_lvl]);
            if (sum >= SW'(NUM_TASKS))
            begin
                push_slot = TW'(sum - SW'(NUM_TASKS));
            end
            else
            begin
                push_slot = TW'(sum);
            end
        end
    end

    // Highest non-empty level wins.
    always_comb
    begin
        any_ready = 1'b0;
        pop_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                any_ready = 1'b1;
                pop_lvl   = LW'(l);
            end
        end
        pop_slot = head_reg[pop_lvl];
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            cnt_next[l]  = cnt_reg[l];
            if (ctl.push && push_ok && push_lvl == LW'(l))
            begin
                cnt_next[l] = cnt_reg[l] + CW'(1);
            end
            if (ctl.pop && any_ready && pop_lvl == LW'(l))
            begin
                cnt_next[l] = cnt_reg[l] - CW'(1);
                if (head_reg[l] == TW'(NUM_TASKS - 1))
                begin
                    head_next[l] = '0;
                end
                else
                begin
                    head_next[l] = head_reg[l] + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
        end
    end

endmodule

@@ hw/rtl/multilevel_feedback_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Task scheduler with FIFO ready levels and a sleep list kept in RAM.
// ----------------------------------------------------------------------------
// Sequence: admit reads and rewrites the task record; a tick or a sleep walks
//   the sleep list with a read-list / read-task / update pass per sleep entry.
// Throughput: one command at a time; busy stays high until the result beat.
// Reset: asynchronous, active low; levels and sleep list empty, no task
//   running. RAM contents stay undefined; counts guard every read.
// The receiver cannot stall: done marks a one-cycle result beat.
module multilevel_feedback_scheduler_unit
    import mfs_pkg::*;
#(
    parameter int NUM_TASKS  = MFS_NUM_TASKS,
    parameter int NUM_LEVELS = MFS_NUM_LEVELS,
    localparam int TW = $clog2(NUM_TASKS),
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [TW-1:0]       task_id,
    input  logic [LVL_IN_W-1:0] task_level,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [TIME_W-1:0]   sleep_duration,
    output logic                done,
    output logic [TW-1:0]       run_task,
    output logic                run_valid,
    output logic [LW-1:0]       run_level
);

    localparam int CW     = $clog2(NUM_TASKS + 1);
    localparam int LDEPTH = (NUM_LEVELS + 1) * NUM_TASKS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int TRW    = TIME_W + LW;
    localparam int LMAX   = NUM_LEVELS - 1;
    localparam logic [TW:0] NT_X = (TW + 1)'(NUM_TASKS);
    // Sleep list lives above the ready levels in the list RAM.
    localparam logic [LAW-1:0] SLEEP_BASE = LAW'(NUM_LEVELS * NUM_TASKS);

    mfs_state_t state_reg, state_next;

    logic [TW-1:0]     id_reg,       id_next;
    logic [LW-1:0]     lvl_reg,      lvl_next;
    logic [TIME_W-1:0] now_reg,      now_next;
    logic [TIME_W-1:0] dur_reg,      dur_next;
    logic [TW-1:0]     run_id_reg,   run_id_next;
    logic              run_flag_reg, run_flag_next;
    logic [CW-1:0]     sleep_cnt_reg, sleep_cnt_next;
    logic [CW-1:0]     rd_idx_reg,   rd_idx_next;
    logic [CW-1:0]     wr_idx_reg,   wr_idx_next;
    logic              done_reg,     done_next;
    logic [TW-1:0]     out_task_reg, out_task_next;
    logic              out_valid_reg, out_valid_next;
    logic [LW-1:0]     out_level_reg, out_level_next;

    // List RAM: ready FIFO entries and sleep list, task ids.
    logic           list_we;
    logic [LAW-1:0] list_waddr, list_raddr;
    logic [TW-1:0]  list_wdata, list_rdata;

    // Task RAM: {deadline, priority level} per task.
    logic           task_we;
    logic [TW-1:0]  task_waddr, task_raddr;
    logic [TRW-1:0] task_wdata, task_rdata;

    lvl_ctl_t       lctl;
    logic [LW-1:0]  push_lvl, pop_lvl;
    logic           push_ok, any_ready;
    logic [TW-1:0]  push_slot, pop_slot;

    logic [TW-1:0]     id_in;
    logic [LW-1:0]     adm_lvl;
    logic [LW-1:0]     rec_prio, rec_demoted;
    logic [TIME_W-1:0] rec_deadline;

    mfs_ram #(.WIDTH(TW), .DEPTH(LDEPTH)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    mfs_ram #(.WIDTH(TRW), .DEPTH(NUM_TASKS)) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .waddr (task_waddr),
        .wdata (task_wdata),
        .raddr (task_raddr),
        .rdata (task_rdata)
    );

    mfs_levels #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_levels (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lctl),
        .push_lvl  (push_lvl),
        .push_ok   (push_ok),
        .push_slot (push_slot),
        .any_ready (any_ready),
        .pop_lvl   (pop_lvl),
        .pop_slot  (pop_slot)
    );

    // Fold the id into range and demote the given level by one, capped.
    always_comb
    begin
        if ({1'b0, task_id} >= NT_X)
        begin
            id_in = TW'({1'b0, task_id} - NT_X);
        end
        else
        begin
            id_in = task_id;
        end
        if (task_level < LVL_IN_W'(LMAX))
        begin
            adm_lvl = LW'(task_level + LVL_IN_W'(1));
        end
        else
        begin
            adm_lvl = LW'(LMAX);
        end
    end

    // Fields of the task record that just came out of the RAM.
    assign rec_prio     = task_rdata[LW-1:0];
    assign rec_deadline = task_rdata[TRW-1:LW];
    assign rec_demoted  = (rec_prio < LW'(LMAX)) ? rec_prio + LW'(1) : LW'(LMAX);

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        lvl_next       = lvl_reg;
        now_next       = now_reg;
        dur_next       = dur_reg;
        run_id_next    = run_id_reg;
        run_flag_next  = run_flag_reg;
        sleep_cnt_next = sleep_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        done_next      = 1'b0;
        out_task_next  = out_task_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;

        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        list_raddr = '0;
        task_we    = 1'b0;
        task_waddr = '0;
        task_wdata = '0;
        task_raddr = '0;
        lctl       = '0;
        push_lvl   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                if (start)
                begin
                    id_next  = id_in;
                    lvl_next = adm_lvl;
                    now_next = now_time;
                    dur_next = sleep_duration;
                    priority case (op)
                        OP_ADMIT:    state_next = S_ADM_RD;
                        OP_SCHEDULE: state_next = S_WK_LIST;
                        OP_SLEEP:    state_next = S_SLP_RD;
                        default:     state_next = S_OUT_RD;
                    endcase
                end
            end

            S_ADM_RD:
            begin
                task_raddr = id_reg;
                state_next = S_ADM_WR;
            end

            S_ADM_WR:
            begin
                // Keep the deadline, set the new level, queue the task.
                task_we    = 1'b1;
                task_waddr = id_reg;
                task_wdata = {rec_deadline, lvl_reg};
                lctl.push  = 1'b1;
                push_lvl   = lvl_reg;
                list_we    = push_ok;
                list_waddr = LAW'(lvl_reg) * LAW'(NUM_TASKS) + LAW'(push_slot);
                list_wdata = id_reg;
                state_next = S_OUT_RD;
            end

            S_SLP_RD:
            begin
                task_raddr = run_id_reg;
                if (run_flag_reg)
                begin
                    state_next = S_SLP_WR;
                end
                else
                begin
                    state_next = S_WK_LIST;
                end
            end

            S_SLP_WR:
            begin
                task_we    = 1'b1;
                task_waddr = run_id_reg;
                task_wdata = {now_reg + dur_reg, rec_prio};
                if (sleep_cnt_reg < CW'(NUM_TASKS))
                begin
                    list_we        = 1'b1;
                    list_waddr     = SLEEP_BASE + LAW'(sleep_cnt_reg);
                    list_wdata     = run_id_reg;
                    sleep_cnt_next = sleep_cnt_reg + CW'(1);
                end
                // A full sleep list drops the task.
                run_flag_next = 1'b0;
                state_next    = S_WK_LIST;
            end

            S_WK_LIST:
            begin
                list_raddr = SLEEP_BASE + LAW'(rd_idx_reg);
                if (rd_idx_reg == sleep_cnt_reg)
                begin
                    sleep_cnt_next = wr_idx_reg;
                    state_next     = S_REQ_RD;
                end
                else
                begin
                    state_next = S_WK_TASK;
                end
            end

            S_WK_TASK:
            begin
                id_next    = list_rdata;
                task_raddr = list_rdata;
                state_next = S_WK_UPD;
            end

            S_WK_UPD:
            begin
                // Wake and demote the sleeper, or compact it down the list.
                if (now_reg >= rec_deadline)
                begin
                    task_we    = 1'b1;
                    task_waddr = id_reg;
                    task_wdata = {rec_deadline, rec_demoted};
                    lctl.push  = 1'b1;
                    push_lvl   = rec_demoted;
                    list_we    = push_ok;
                    list_waddr = LAW'(rec_demoted) * LAW'(NUM_TASKS) + LAW'(push_slot);
                    list_wdata = id_reg;
                end
                else
                begin
                    list_we     = 1'b1;
                    list_waddr  = SLEEP_BASE + LAW'(wr_idx_reg);
                    list_wdata  = id_reg;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                rd_idx_next = rd_idx_reg + CW'(1);
                state_next  = S_WK_LIST;
            end

            S_REQ_RD:
            begin
                task_raddr = run_id_reg;
                if (run_flag_reg)
                begin
                    state_next = S_REQ_WR;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_REQ_WR:
            begin
                // Demote and requeue the running task.
                task_we    = 1'b1;
                task_waddr = run_id_reg;
                task_wdata = {rec_deadline, rec_demoted};
                lctl.push  = 1'b1;
                push_lvl   = rec_demoted;
                list_we    = push_ok;
                list_waddr = LAW'(rec_demoted) * LAW'(NUM_TASKS) + LAW'(push_slot);
                list_wdata = run_id_reg;
                state_next = S_PICK;
            end

            S_PICK:
            begin
                list_raddr = LAW'(pop_lvl) * LAW'(NUM_TASKS) + LAW'(pop_slot);
                if (any_ready)
                begin
                    lctl.pop   = 1'b1;
                    state_next = S_PICK_WR;
                end
                else
                begin
                    run_flag_next = 1'b0;
                    state_next    = S_OUT_RD;
                end
            end

            S_PICK_WR:
            begin
                run_id_next   = list_rdata;
                run_flag_next = 1'b1;
                state_next    = S_OUT_RD;
            end

            S_OUT_RD:
            begin
                task_raddr = run_id_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                done_next      = 1'b1;
                out_valid_next = run_flag_reg;
                out_task_next  = run_flag_reg ? run_id_reg : '0;
                out_level_next = run_flag_reg ? rec_prio : '0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_id_reg    <= '0;
            run_flag_reg  <= 1'b0;
            sleep_cnt_reg <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_id_reg    <= run_id_next;
            run_flag_reg  <= run_flag_next;
            sleep_cnt_reg <= sleep_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        lvl_reg       <= lvl_next;
        now_reg       <= now_next;
        dur_reg       <= dur_next;
        out_task_reg  <= out_task_next;
        out_level_reg <= out_level_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign run_task  = out_task_reg;
    assign run_valid = out_valid_reg;
    assign run_level = out_level_reg;

endmodule

@@ hw/rtl/mfs_checker.sv @@
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks of the scheduler command and result beats.
// ----------------------------------------------------------------------------
module mfs_checker
    import mfs_pkg::*;
#(
    parameter int NUM_TASKS  = MFS_NUM_TASKS,
    parameter int NUM_LEVELS = MFS_NUM_LEVELS,
    localparam int TW = $clog2(NUM_TASKS),
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [OP_W-1:0]     op,
    input logic [TW-1:0]       task_id,
    input logic [LVL_IN_W-1:0] task_level,
    input logic [TIME_W-1:0]   now_time,
    input logic [TIME_W-1:0]   sleep_duration,
    input logic                done,
    input logic [TW-1:0]       run_task,
    input logic                run_valid,
    input logic [LW-1:0]       run_level
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat outside a command");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !run_valid |-> run_task == '0 && run_level == '0)
        else $error("idle result carries nonzero fields");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && run_valid |-> run_level <= LW'(NUM_LEVELS - 1))
        else $error("run level out of range");

endmodule

bind multilevel_feedback_scheduler_unit mfs_checker #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
) u_mfs_checker (.*);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel feedback scheduler: a directed set of
// commands, then random admit / tick / sleep / unknown-op traffic, each result beat checked
// against a behavioral model of the levels, the sleep list and the runner.
// ----------------------------------------------------------------------------
module tb;
    import mfs_pkg::*;

    localparam int NT = MFS_NUM_TASKS;
    localparam int NL = MFS_NUM_LEVELS;
    localparam int WATCHDOG_LIMIT = 20000;

    // One predicted run state.
    typedef struct packed {
        logic [3:0] task_no;
        logic       active;
        logic [2:0] level;
    } run_state_t;

    // Behavioral scheduler model plus queue of predicted run states.
    class sched_scoreboard;
        logic [3:0]  ready_q [NL][NT];
        int          head [NL];
        int          count [NL];
        logic [2:0]  prio [NT];
        logic [31:0] deadline [NT];
        logic [3:0]  sleepers [NT];
        int          n_sleep;
        logic [3:0]  cur_id;
        logic        cur_on;
        run_state_t  pending [$];
        int          mismatches;
        int          beats_checked;

        function new();
            for (int l = 0; l < NL; l++)
            begin
                head[l] = 0;
                count[l] = 0;
            end
            for (int t = 0; t < NT; t++)
            begin
                prio[t] = '0;
                deadline[t] = '0;
            end
            n_sleep = 0;
            cur_id = '0;
            cur_on = 1'b0;
            mismatches = 0;
            beats_checked = 0;
        endfunction

        function void demote_enqueue(logic [3:0] id, int lvl);
            int nxt;
            nxt = (lvl < NL - 1) ? lvl + 1 : NL - 1;
            prio[id] = 3'(nxt);
            if (count[nxt] < NT)
            begin
                ready_q[nxt][(head[nxt] + count[nxt]) % NT] = id;
                count[nxt]++;
            end
        endfunction

        function void tick(logic [31:0] now_t);
            int w;
            w = 0;
            for (int r = 0; r < n_sleep; r++)
            begin
                if (now_t >= deadline[sleepers[r]])
                    demote_enqueue(sleepers[r], prio[sleepers[r]]);
                else
                begin
                    sleepers[w] = sleepers[r];
                    w++;
                end
            end
            n_sleep = w;
            if (cur_on)
                demote_enqueue(cur_id, prio[cur_id]);
            cur_on = 1'b0;
            for (int l = 0; l < NL; l++)
            begin
                if (count[l] != 0)
                begin
                    cur_id = ready_q[l][head[l]];
                    head[l] = (head[l] + 1) % NT;
                    count[l]--;
                    cur_on = 1'b1;
                    break;
                end
            end
        endfunction

        // Note an accepted command beat and predict its result.
        function void note_command(logic [1:0] opc, logic [3:0] id, logic [2:0] lvl,
                                   logic [31:0] now_t, logic [31:0] dur);
            run_state_t e;
            if (opc == OP_ADMIT)
                demote_enqueue(id, lvl);
            else if (opc == OP_SCHEDULE)
                tick(now_t);
            else if (opc == OP_SLEEP)
            begin
                if (cur_on)
                begin
                    deadline[cur_id] = now_t + dur;
                    if (n_sleep < NT)
                    begin
                        sleepers[n_sleep] = cur_id;
                        n_sleep++;
                    end
                    cur_on = 1'b0;
                end
                tick(now_t);
            end
            e.task_no = cur_on ? cur_id : 4'd0;
            e.active = cur_on;
            e.level = cur_on ? prio[cur_id] : 3'd0;
            pending.push_back(e);
        endfunction

        // Check one result beat against the oldest prediction.
        function void check_result(logic [3:0] t, logic v, logic [2:0] l);
            run_state_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: task %0d valid %0b level %0d",
                             t, v, l);
                return;
            end
            e = pending.pop_front();
            beats_checked++;
            if (t !== e.task_no || v !== e.active || l !== e.level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected task %0d valid %0b level %0d, got task %0d valid %0b level %0d",
                             e.task_no, e.active, e.level, t, v, l);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  task_id;
    logic [2:0]  task_level;
    logic [31:0] now_time;
    logic [31:0] sleep_duration;
    logic        done;
    logic [3:0]  run_task;
    logic        run_valid;
    logic [2:0]  run_level;

    sched_scoreboard sb;
    int          idle_cycles;
    int          n_admit;
    int          n_tick;
    int          n_sleep_cmds;
    int          n_other;
    logic [31:0] clock_now;

    multilevel_feedback_scheduler_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .task_id        (task_id),
        .task_level     (task_level),
        .now_time       (now_time),
        .sleep_duration (sleep_duration),
        .done           (done),
        .run_task       (run_task),
        .run_valid      (run_valid),
        .run_level      (run_level)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Check every result beat; the receiver cannot hold results off.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(run_task, run_valid, run_level);
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("multilevel_feedback_scheduler_unit test failed");
            $finish;
        end
    end

    // Issue one command beat and hold it until the block takes it.
    task automatic send_command(logic [1:0] opc, logic [3:0] id, logic [2:0] lvl,
                                logic [31:0] now_t, logic [31:0] dur);
        start <= 1'b1;
        op <= opc;
        task_id <= id;
        task_level <= lvl;
        now_time <= now_t;
        sleep_duration <= dur;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(opc, id, lvl, now_t, dur);
        case (opc)
            OP_ADMIT:    n_admit++;
            OP_SCHEDULE: n_tick++;
            OP_SLEEP:    n_sleep_cmds++;
            default:     n_other++;
        endcase
    endtask

    // Drop start for a number of cycles.
    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Pause until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: admits, ticks with an advancing clock,
    // sleeps of short and wrapping lengths, a little unknown-op noise.
    task automatic random_command();
        int          pick;
        logic [31:0] dur;
        pick = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, 40);
        if ($urandom_range(0, 49) == 0)
            clock_now = $urandom;
        dur = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 120));
        if (pick < 35)
            send_command(OP_ADMIT, 4'($urandom), 3'($urandom), $urandom, $urandom);
        else if (pick < 70)
            send_command(OP_SCHEDULE, 4'($urandom), 3'($urandom), clock_now, $urandom);
        else if (pick < 95)
            send_command(OP_SLEEP, 4'($urandom), 3'($urandom), clock_now, dur);
        else
            send_command(2'd3, 4'($urandom), 3'($urandom), $urandom, $urandom);
    endtask

    initial
    begin
        int burst;
        sb = new();
        idle_cycles = 0;
        n_admit = 0;
        n_tick = 0;
        n_sleep_cmds = 0;
        n_other = 0;
        clock_now = 32'd1000;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ADMIT;
        task_id = '0;
        task_level = '0;
        now_time = '0;
        sleep_duration = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick and sleep with nothing running, unknown op.
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'd0, 32'd0);
        send_command(OP_SLEEP, 4'd0, 3'd0, 32'd0, 32'd5);
        send_command(2'd3, 4'd15, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Level extremes, including out-of-range levels.
        send_command(OP_ADMIT, 4'd0, 3'd0, 32'd0, 32'd0);
        send_command(OP_ADMIT, 4'd15, 3'd4, 32'd0, 32'd0);
        send_command(OP_ADMIT, 4'd7, 3'd7, 32'd0, 32'd0);
        send_command(OP_ADMIT, 4'd8, 3'd3, 32'd0, 32'd0);
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'd10, 32'd0);
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'd11, 32'd0);
        // Sleep with a wrapping deadline: wakes at the next check.
        send_command(OP_SLEEP, 4'd0, 3'd0, 32'hFFFF_FFF0, 32'h0000_0020);
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'hFFFF_FFF1, 32'd0);
        send_command(OP_SLEEP, 4'd0, 3'd0, 32'd100, 32'd50);
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'd149, 32'd0);
        send_command(OP_SCHEDULE, 4'd0, 3'd0, 32'd150, 32'd0);
        // Overfill the lowest level so a push gets dropped.
        for (int i = 0; i < 18; i++)
            send_command(OP_ADMIT, 4'(i), 3'd6, 32'd0, 32'd0);
        drain_results();

        // Random traffic in bursts, with a full drain now and then.
        for (int i = 0; i < 950;)
        begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst && i < 950; j++)
            begin
                random_command();
                i++;
            end
            if ($urandom_range(0, 9) == 0)
                drain_results();
            else if ($urandom_range(0, 2) != 0)
                hold_off($urandom_range(1, 40));
        end

        drain_results();
        repeat (120)
            @(posedge clk);

        $display("covered %0d admits, %0d ticks, %0d sleeps, %0d unknown ops; %0d beats checked",
                 n_admit, n_tick, n_sleep_cmds, n_other, sb.beats_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("multilevel_feedback_scheduler_unit test passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("multilevel_feedback_scheduler_unit test failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_ram.sv
hw/rtl/mfs_levels.sv
hw/rtl/multilevel_feedback_scheduler_unit.sv
hw/rtl/mfs_checker.sv
bench/tb.sv
